>>> sv/macd_crossover_signal_core_assert.svh
// Assertion macros shared by the checker of the MACD crossover core.
// No dependencies; the user supplies clk and rst in scope.
`ifndef MACD_CROSSOVER_SIGNAL_CORE_ASSERT_SVH
`define MACD_CROSSOVER_SIGNAL_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mcs_pkg.sv
// Shared types, constants and microcode ROM of the MACD crossover core.
// No dependencies.
package mcs_pkg;

  localparam int WEIGHT_FRAC = 16;
  localparam int ALPHA_W = 17;
  localparam int ALPHA_MUL_W = ALPHA_W + 1;
  localparam logic [ALPHA_W-1:0] WEIGHT_ONE = 17'd65536;

  localparam logic [ALPHA_W-1:0] ALPHA_FAST_RST = 17'd10082;
  localparam logic [ALPHA_W-1:0] ALPHA_SLOW_RST = 17'd4855;
  localparam logic [ALPHA_W-1:0] ALPHA_SIGNAL_RST = 17'd13107;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FAST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SLOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SIGNAL = 2'd2;

  localparam logic signed [1:0] TRADE_NONE = 2'sd0;
  localparam logic signed [1:0] TRADE_BUY = 2'sd1;
  localparam logic signed [1:0] TRADE_SELL = -2'sd1;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_WAIT = 4'd0;
  localparam step_t ST_MLO_FAST = 4'd1;
  localparam step_t ST_MHI_FAST = 4'd2;
  localparam step_t ST_MLO_SLOW = 4'd3;
  localparam step_t ST_MHI_SLOW = 4'd4;
  localparam step_t ST_UPD_SLOW = 4'd5;
  localparam step_t ST_MACD = 4'd6;
  localparam step_t ST_MLO_SIG = 4'd7;
  localparam step_t ST_MHI_SIG = 4'd8;
  localparam step_t ST_UPD_SIG = 4'd9;
  localparam step_t ST_OUT = 4'd10;
  localparam step_t ST_SEED = 4'd11;

  typedef enum logic [1:0] {SEL_FAST, SEL_SLOW, SEL_SIG} ema_sel_t;
  typedef enum logic {HALF_LO, HALF_HI} mul_half_t;
  typedef enum logic [1:0] {JMP_NONE, JMP_UNSEEDED, JMP_ALWAYS} jmp_t;

  typedef struct packed {
    logic wait_in;
    logic wait_out;
    logic mul_en;
    mul_half_t half;
    ema_sel_t mul_sel;
    logic acc_load;
    logic upd_en;
    ema_sel_t upd_sel;
    logic macd_load;
    logic seed_load;
    jmp_t jmp;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic unseeded;
  } seq_status_t;

  // Microprogram: fast, slow and signal EMA share the multiplier, the fast update
  // overlaps the slow low-half product.
  function automatic ctrl_word_t micro_rom(input step_t step);
    ctrl_word_t w;
    w = '0;
    unique case (step)
      ST_WAIT: begin
        w.wait_in = 1'b1;
      end
      ST_MLO_FAST: begin
        w.mul_en = 1'b1;
        w.half = HALF_LO;
        w.mul_sel = SEL_FAST;
        w.jmp = JMP_UNSEEDED;
        w.target = ST_SEED;
      end
      ST_MHI_FAST: begin
        w.mul_en = 1'b1;
        w.half = HALF_HI;
        w.mul_sel = SEL_FAST;
        w.acc_load = 1'b1;
      end
      ST_MLO_SLOW: begin
        w.mul_en = 1'b1;
        w.half = HALF_LO;
        w.mul_sel = SEL_SLOW;
        w.upd_en = 1'b1;
        w.upd_sel = SEL_FAST;
      end
      ST_MHI_SLOW: begin
        w.mul_en = 1'b1;
        w.half = HALF_HI;
        w.mul_sel = SEL_SLOW;
        w.acc_load = 1'b1;
      end
      ST_UPD_SLOW: begin
        w.upd_en = 1'b1;
        w.upd_sel = SEL_SLOW;
      end
      ST_MACD: begin
        w.macd_load = 1'b1;
      end
      ST_MLO_SIG: begin
        w.mul_en = 1'b1;
        w.half = HALF_LO;
        w.mul_sel = SEL_SIG;
      end
      ST_MHI_SIG: begin
        w.mul_en = 1'b1;
        w.half = HALF_HI;
        w.mul_sel = SEL_SIG;
        w.acc_load = 1'b1;
      end
      ST_UPD_SIG: begin
        w.upd_en = 1'b1;
        w.upd_sel = SEL_SIG;
      end
      ST_OUT: begin
        w.wait_out = 1'b1;
        w.jmp = JMP_ALWAYS;
        w.target = ST_WAIT;
      end
      ST_SEED: begin
        w.seed_load = 1'b1;
        w.jmp = JMP_ALWAYS;
        w.target = ST_OUT;
      end
      default: begin
        w.jmp = JMP_ALWAYS;
        w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

>>> sv/mcs_seq.sv
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on mcs_pkg.
module mcs_seq (
  input  logic                clk,
  input  logic                rst,
  input  mcs_pkg::seq_status_t status,
  output mcs_pkg::ctrl_word_t  ctrl
);

  mcs_pkg::step_t step;
  mcs_pkg::step_t step_next;
  logic hold;
  logic taken;

  assign ctrl = mcs_pkg::micro_rom(step);

  always_comb begin
    hold = (ctrl.wait_in && !status.in_valid) || (ctrl.wait_out && !status.out_free);
    taken = (ctrl.jmp == mcs_pkg::JMP_ALWAYS) ||
            (ctrl.jmp == mcs_pkg::JMP_UNSEEDED && status.unseeded);
    if (hold) begin
      step_next = step;
    end else if (taken) begin
      step_next = ctrl.target;
    end else begin
      step_next = step + mcs_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= mcs_pkg::ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> sv/mcs_datapath.sv
// Datapath: weight registers, EMA state, shared split multiplier, result register.
// Depends on mcs_pkg; driven by mcs_seq control words.
module mcs_datapath #(
  parameter int PRICE_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mcs_pkg::ctrl_word_t                    ctrl,
  input  logic                                   price_valid,
  input  logic [PRICE_BITS-1:0]                  price,
  input  logic                                   cfg_valid,
  input  logic [mcs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mcs_pkg::ALPHA_W-1:0]            cfg_data,
  input  logic                                   result_stall,
  output mcs_pkg::seq_status_t                   status,
  output logic                                   result_valid,
  output logic signed [PRICE_BITS+FRAC_BITS:0]   macd_value,
  output logic signed [PRICE_BITS+FRAC_BITS:0]   signal_value,
  output logic signed [PRICE_BITS+FRAC_BITS+1:0] histogram,
  output logic signed [1:0]                      trade_signal
);

  localparam int AW = PRICE_BITS + FRAC_BITS;
  localparam int DW = AW + 2;
  localparam int LO_W = (DW + 1) / 2;
  localparam int HI_W = DW - LO_W;
  localparam int OP_W = LO_W + 1;
  localparam int PW = OP_W + mcs_pkg::ALPHA_MUL_W;
  localparam int SW = PW + LO_W;

  logic [mcs_pkg::ALPHA_W-1:0] alpha_fast;
  logic [mcs_pkg::ALPHA_W-1:0] alpha_slow;
  logic [mcs_pkg::ALPHA_W-1:0] alpha_signal;
  logic [mcs_pkg::ALPHA_W-1:0] cfg_weight;
  logic seeded;

  logic [PRICE_BITS-1:0] price_reg;
  logic [AW-1:0] fast_avg;
  logic [AW-1:0] slow_avg;
  logic signed [AW:0] signal_avg;
  logic signed [AW:0] macd_reg;
  logic signed [AW:0] prev_macd;
  logic signed [AW:0] sig_prev;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] acc;

  logic [AW-1:0] price_fix;
  logic signed [DW-1:0] mul_x;
  logic signed [DW-1:0] mul_avg;
  logic [mcs_pkg::ALPHA_W-1:0] mul_alpha;
  logic signed [DW-1:0] diff;
  logic signed [OP_W-1:0] mul_op;
  logic signed [mcs_pkg::ALPHA_MUL_W-1:0] mul_a;
  logic signed [PW-1:0] product;
  logic signed [DW-1:0] upd_base;
  logic signed [SW-1:0] wsum;
  logic signed [DW-1:0] upd_val;
  logic signed [DW-1:0] hist;
  logic signed [DW-1:0] prev_diff;
  logic buy;
  logic sell;
  logic out_load;
  logic in_fire;

  assign in_fire = ctrl.wait_in && price_valid;
  assign status.in_valid = price_valid;
  assign status.out_free = !result_valid || !result_stall;
  assign status.unseeded = !seeded;
  assign out_load = ctrl.wait_out && status.out_free;

  // Weights above one saturate at the write.
  assign cfg_weight = (cfg_data > mcs_pkg::WEIGHT_ONE) ? mcs_pkg::WEIGHT_ONE : cfg_data;
  assign price_fix = {price_reg, {FRAC_BITS{1'b0}}};

  always_comb begin
    case (ctrl.mul_sel)
      mcs_pkg::SEL_FAST: begin
        mul_x = {2'b00, price_fix};
        mul_avg = {2'b00, fast_avg};
        mul_alpha = alpha_fast;
      end
      mcs_pkg::SEL_SLOW: begin
        mul_x = {2'b00, price_fix};
        mul_avg = {2'b00, slow_avg};
        mul_alpha = alpha_slow;
      end
      default: begin
        mul_x = {macd_reg[AW], macd_reg};
        mul_avg = {signal_avg[AW], signal_avg};
        mul_alpha = alpha_signal;
      end
    endcase
    diff = mul_x - mul_avg;
    // Difference split in two halves: unsigned low, signed high.
    if (ctrl.half == mcs_pkg::HALF_LO) begin
      mul_op = {1'b0, diff[LO_W-1:0]};
    end else begin
      mul_op = {{(OP_W-HI_W){diff[DW-1]}}, diff[DW-1:LO_W]};
    end
    mul_a = {1'b0, mul_alpha};
    product = mul_op * mul_a;
  end

  always_comb begin
    case (ctrl.upd_sel)
      mcs_pkg::SEL_FAST: upd_base = {2'b00, fast_avg};
      mcs_pkg::SEL_SLOW: upd_base = {2'b00, slow_avg};
      default:           upd_base = {signal_avg[AW], signal_avg};
    endcase
    // prod holds the high partial product, acc the low one; floor by bit select.
    wsum = {prod, {LO_W{1'b0}}} + {{LO_W{acc[PW-1]}}, acc};
    upd_val = upd_base + wsum[DW+mcs_pkg::WEIGHT_FRAC-1:mcs_pkg::WEIGHT_FRAC];
  end

  always_comb begin
    hist = {macd_reg[AW], macd_reg} - {signal_avg[AW], signal_avg};
    prev_diff = {prev_macd[AW], prev_macd} - {sig_prev[AW], sig_prev};
    buy = (prev_diff[DW-1] || prev_diff == '0) && !hist[DW-1] && hist != '0;
    sell = !prev_diff[DW-1] && hist[DW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_fast <= mcs_pkg::ALPHA_FAST_RST;
      alpha_slow <= mcs_pkg::ALPHA_SLOW_RST;
      alpha_signal <= mcs_pkg::ALPHA_SIGNAL_RST;
      seeded <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          mcs_pkg::REG_ALPHA_FAST:   alpha_fast <= cfg_weight;
          mcs_pkg::REG_ALPHA_SLOW:   alpha_slow <= cfg_weight;
          mcs_pkg::REG_ALPHA_SIGNAL: alpha_signal <= cfg_weight;
          default: ;
        endcase
      end
      if (ctrl.seed_load) begin
        seeded <= 1'b1;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      price_reg <= price;
    end
    if (ctrl.mul_en) begin
      prod <= product;
    end
    if (ctrl.acc_load) begin
      acc <= prod;
    end
    if (ctrl.upd_en) begin
      case (ctrl.upd_sel)
        mcs_pkg::SEL_FAST: fast_avg <= upd_val[AW-1:0];
        mcs_pkg::SEL_SLOW: slow_avg <= upd_val[AW-1:0];
        default: begin
          signal_avg <= upd_val[AW:0];
          sig_prev <= signal_avg;
        end
      endcase
    end
    if (ctrl.macd_load) begin
      macd_reg <= {1'b0, fast_avg} - {1'b0, slow_avg};
    end
    if (ctrl.seed_load) begin
      fast_avg <= price_fix;
      slow_avg <= price_fix;
      signal_avg <= '0;
      macd_reg <= '0;
      prev_macd <= '0;
      sig_prev <= '0;
    end
    if (out_load) begin
      macd_value <= macd_reg;
      signal_value <= signal_avg;
      histogram <= hist;
      trade_signal <= buy ? mcs_pkg::TRADE_BUY :
                      (sell ? mcs_pkg::TRADE_SELL : mcs_pkg::TRADE_NONE);
      prev_macd <= macd_reg;
    end
  end

endmodule

>>> sv/macd_crossover_signal_core.sv
// MACD 12/26/9 crossover core, top level: sequencer plus datapath.
// Depends on mcs_pkg, mcs_seq and mcs_datapath.
//
// Usage:
//  - Price channel: price_valid/price_stall, one closing price per beat.
//    price_stall is low only while the sequencer waits for a new item.
//  - Result channel: result_valid/result_stall, one beat per price with
//    macd_value, signal_value, histogram and trade_signal (+1 buy, -1 sell).
//  - Config channel: cfg_valid/cfg_ready (always ready), cfg_index picks
//    alpha_fast, alpha_slow or alpha_signal; other indexes are dropped.
//    Weights are Q1.16 and clip at 1.0. Write only while the core is idle.
//  - Microprogram: it drives one shared multiplier, two half-width
//    products per EMA. A normal price runs the fast and slow EMA steps, the
//    MACD step and the signal EMA step, in that order, before its output
//    step; the first price after reset only seeds the EMAs.
//  - The result register holds while result_stall is high; the sequencer
//    waits at its output step, so one more price can be taken and worked
//    on while a finished result waits.
//  - Reset (rst, synchronous) restores the default weights and unseeds
//    the averages; nothing else needs clearing.
module macd_crossover_signal_core #(
  parameter int PRICE_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   price_valid,
  output logic                                   price_stall,
  input  logic [PRICE_BITS-1:0]                  price,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [PRICE_BITS+FRAC_BITS:0]   macd_value,
  output logic signed [PRICE_BITS+FRAC_BITS:0]   signal_value,
  output logic signed [PRICE_BITS+FRAC_BITS+1:0] histogram,
  output logic signed [1:0]                      trade_signal,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mcs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mcs_pkg::ALPHA_W-1:0]            cfg_data
);

  mcs_pkg::ctrl_word_t ctrl;
  mcs_pkg::seq_status_t status;

  // Config writes go straight into the weight registers.
  assign cfg_ready = 1'b1;
  // Price beats are taken only at the wait step of the microprogram.
  assign price_stall = !ctrl.wait_in;

  mcs_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  mcs_datapath #(
    .PRICE_BITS (PRICE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .price_valid  (price_valid),
    .price        (price),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_stall (result_stall),
    .status       (status),
    .result_valid (result_valid),
    .macd_value   (macd_value),
    .signal_value (signal_value),
    .histogram    (histogram),
    .trade_signal (trade_signal)
  );

endmodule

>>> sv/mcs_checker.sv
// Port-level checker for the MACD crossover core, bound to the top level.
// Depends on mcs_pkg and macd_crossover_signal_core_assert.svh.
`include "macd_crossover_signal_core_assert.svh"

module mcs_checker #(
  parameter int PRICE_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   price_valid,
  input logic                                   price_stall,
  input logic                                   result_valid,
  input logic                                   result_stall,
  input logic signed [PRICE_BITS+FRAC_BITS:0]   macd_value,
  input logic signed [PRICE_BITS+FRAC_BITS:0]   signal_value,
  input logic signed [PRICE_BITS+FRAC_BITS+1:0] histogram,
  input logic signed [1:0]                      trade_signal
);

  localparam int HW = PRICE_BITS + FRAC_BITS + 2;

  logic signed [HW-1:0] hist_chk;
  assign hist_chk = {macd_value[HW-2], macd_value} - {signal_value[HW-2], signal_value};

  `MCS_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
    result_valid && $stable(macd_value) && $stable(trade_signal), "stalled result moved")

  `MCS_ASSERT_NEXT(a_one_item, price_valid && !price_stall, price_stall,
    "price taken while an item is in work")

  `MCS_ASSERT_NOW(a_hist, result_valid, histogram == hist_chk,
    "histogram is not macd minus signal")

  `MCS_ASSERT_NOW(a_buy, result_valid && trade_signal == mcs_pkg::TRADE_BUY,
    !histogram[HW-1] && histogram != '0, "buy without macd above signal")

  `MCS_ASSERT_NOW(a_sell, result_valid && trade_signal == mcs_pkg::TRADE_SELL,
    histogram[HW-1], "sell without macd below signal")

endmodule

bind macd_crossover_signal_core mcs_checker #(
  .PRICE_BITS (PRICE_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_chk (
  .clk          (clk),
  .rst          (rst),
  .price_valid  (price_valid),
  .price_stall  (price_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .macd_value   (macd_value),
  .signal_value (signal_value),
  .histogram    (histogram),
  .trade_signal (trade_signal)
);
